FILE: hw/rtl/dlsq_pkg.sv
package dlsq_pkg;

    localparam int ID_W    = 8;
    localparam int MS_W    = 32;
    localparam int DELTA_W = 29;
    localparam int ENTRY_W = ID_W + DELTA_W;

    // floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
    localparam logic [MS_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int              DIV10_SHIFT = 35;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_TICK = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_WALK_RD,
        S_WALK_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_FIX,
        S_TICK_RD,
        S_TICK_CMP,
        S_DONE
    } t_state;

endpackage

FILE: hw/rtl/dlsq_in_if.sv
interface dlsq_in_if
    import dlsq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              action;
    logic [ID_W-1:0]   process_id;
    logic [MS_W-1:0]   sleep_ms;

    modport source (output valid, action, process_id, sleep_ms, input ready);
    modport sink   (input valid, action, process_id, sleep_ms, output ready);
endinterface

FILE: hw/rtl/dlsq_out_if.sv
interface dlsq_out_if
    import dlsq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              woke;
    logic [ID_W-1:0]   woken_id;
    logic [1:0]        status;

    modport source (output valid, woke, woken_id, status, input ready);
    modport sink   (input valid, woke, woken_id, status, output ready);
endinterface

FILE: hw/rtl/dlsq_div10.sv
module dlsq_div10
    import dlsq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [MS_W-1:0]    i_ms,
    output logic [DELTA_W-1:0] o_ticks
);

    logic [2*MS_W-1:0] r_prod;

    // reciprocal multiply, product registered before the shift
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= (2*MS_W)'(i_ms) * (2*MS_W)'(DIV10_RECIP);
        end
    end

    assign o_ticks = r_prod[DIV10_SHIFT +: DELTA_W];

endmodule

FILE: hw/rtl/delta_list_sleep_queue.sv
// Delta-list sleep queue. Each transaction on i_in gives exactly one transaction on o_out.
// A tick (action 0) reads the head entry from the entry memory, unless the queue is empty,
// then either counts it down or pops it by advancing the ring head. An insert (action 1)
// walks the queued entries; when the new entry lands in front of an existing one, the
// later entries are moved back and the delta of the entry behind it is fixed up. The
// entry memory has one registered read port and one write port, so the walk reads and
// then compares each entry passed and the move reads and then writes each entry moved;
// every subtraction goes through one shared 29-bit subtractor. A full queue rejects an
// insert without a walk. The block takes one transaction at a time and accepts the next
// one in the same cycle as the result becomes valid; a finished result waits in an output
// register while the next transaction is accepted and worked on, and a result that
// cannot enter the output register holds the block until it can. No clearing pass after
// reset: only entries below the fill count are ever read.
module delta_list_sleep_queue
    import dlsq_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dlsq_in_if.sink     i_in,
    dlsq_out_if.source  o_out
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_state r_state, n_state;

    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_head;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_idx;
    logic [ID_W-1:0]    r_id;
    logic [DELTA_W-1:0] r_rem;
    logic               r_has_f;
    logic [ENTRY_W-1:0] r_fword;
    logic               r_woke;
    logic [ID_W-1:0]    r_wid;
    logic [1:0]         r_status;

    logic               r_ovalid;
    logic               r_o_woke;
    logic [ID_W-1:0]    r_o_wid;
    logic [1:0]         r_o_status;

    logic [ENTRY_W-1:0] r_mem [MAX_ENTRIES];
    logic [ENTRY_W-1:0] r_rd_data;

    logic               accept;
    logic               out_free;
    logic [DELTA_W-1:0] ticks;
    logic [DELTA_W-1:0] rd_delta;
    logic [ID_W-1:0]    rd_id;
    logic [DELTA_W-1:0] alu_a, alu_b, alu_diff;
    logic               walk_end;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_lidx, wr_lidx;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [AW-1:0]      idx_m1;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] lidx);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, lidx};
        if (s >= (AW+1)'(MAX_ENTRIES)) begin
            s = s - (AW+1)'(MAX_ENTRIES);
        end
        return s[AW-1:0];
    endfunction

    dlsq_div10 u_div10 (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_ms    (i_in.sleep_ms),
        .o_ticks (ticks)
    );

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;
    assign rd_delta = r_rd_data[DELTA_W-1:0];
    assign rd_id    = r_rd_data[ENTRY_W-1 -: ID_W];
    assign walk_end = (CW'(r_pos) == r_count);
    assign idx_m1   = r_idx - AW'(1);

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ovalid;
    assign o_out.woke     = r_o_woke;
    assign o_out.woken_id = r_o_wid;
    assign o_out.status   = r_o_status;

    // shared subtractor
    always_comb begin
        case (r_state)
            S_WALK_CMP: begin
                alu_a = r_rem;
                alu_b = rd_delta;
            end
            S_TICK_CMP: begin
                alu_a = rd_delta;
                alu_b = DELTA_W'(1);
            end
            S_FIX: begin
                alu_a = r_fword[DELTA_W-1:0];
                alu_b = r_rem;
            end
            default: begin
                alu_a = r_rem;
                alu_b = rd_delta;
            end
        endcase
    end

    assign alu_diff = alu_a - alu_b;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_in.action ? S_DIV : S_TICK_RD;
                end
            end
            S_DIV: begin
                n_state = (r_count == CW'(MAX_ENTRIES)) ? S_DONE : S_WALK_RD;
            end
            S_WALK_RD: begin
                if (walk_end) begin
                    n_state = (r_count[AW-1:0] == r_pos) ? S_PLACE : S_SHIFT_RD;
                end else begin
                    n_state = S_WALK_CMP;
                end
            end
            S_WALK_CMP: begin
                if (r_rem <= rd_delta) begin
                    n_state = (r_count[AW-1:0] == r_pos) ? S_PLACE : S_SHIFT_RD;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = (idx_m1 == r_pos) ? S_PLACE : S_SHIFT_RD;
            S_PLACE:    n_state = r_has_f ? S_FIX : S_DONE;
            S_FIX:      n_state = S_DONE;
            S_TICK_RD:  n_state = (r_count == '0) ? S_DONE : S_TICK_CMP;
            S_TICK_CMP: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        rd_lidx = r_pos;
        wr_lidx = r_idx;
        wr_data = r_rd_data;
        case (r_state)
            S_WALK_RD: begin
                rd_en = !walk_end;
            end
            S_SHIFT_RD: begin
                rd_en   = 1'b1;
                rd_lidx = idx_m1;
            end
            S_SHIFT_WR: begin
                wr_en = 1'b1;
            end
            S_PLACE: begin
                wr_en   = 1'b1;
                wr_lidx = r_pos;
                wr_data = {r_id, r_rem};
            end
            S_FIX: begin
                wr_en   = 1'b1;
                wr_lidx = r_pos + AW'(1);
                wr_data = {r_fword[ENTRY_W-1 -: ID_W], alu_diff};
            end
            S_TICK_RD: begin
                rd_en   = (r_count != '0);
                rd_lidx = '0;
            end
            S_TICK_CMP: begin
                wr_en   = (rd_delta != '0);
                wr_lidx = '0;
                wr_data = {rd_id, alu_diff};
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign rd_addr = f_phys(r_head, rd_lidx);
    assign wr_addr = f_phys(r_head, wr_lidx);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_head  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_id     <= i_in.process_id;
                        r_woke   <= 1'b0;
                        r_wid    <= '0;
                        r_status <= i_in.action ? ST_OK : ST_TICK;
                        r_pos    <= '0;
                        r_has_f  <= 1'b0;
                    end
                end
                S_DIV: begin
                    r_rem <= ticks;
                    r_idx <= r_count[AW-1:0];
                    if (r_count == CW'(MAX_ENTRIES)) begin
                        r_status <= ST_FULL;
                    end
                end
                S_WALK_CMP: begin
                    if (r_rem <= rd_delta) begin
                        // new entry lands in front of this one
                        r_has_f <= 1'b1;
                        r_fword <= r_rd_data;
                    end else begin
                        r_rem <= alu_diff;
                        r_pos <= r_pos + AW'(1);
                    end
                end
                S_SHIFT_WR: begin
                    r_idx <= idx_m1;
                end
                S_PLACE: begin
                    r_count <= r_count + CW'(1);
                end
                S_TICK_CMP: begin
                    if (rd_delta == '0) begin
                        r_woke  <= 1'b1;
                        r_wid   <= rd_id;
                        r_head  <= f_phys(r_head, AW'(1));
                        r_count <= r_count - CW'(1);
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_woke   <= r_woke;
            r_o_wid    <= r_wid;
            r_o_status <= r_status;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1) || r_count == $past(r_count) - CW'(1)))
        else $error("entry count changed by more than one");

    a_woke_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_woke) |-> (r_o_status == ST_TICK))
        else $error("woken result without tick status");

    a_pop_on_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK_CMP && rd_delta == '0) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("wake did not remove the head entry");

endmodule
